@@ hw/rtl/mva_pkg.sv @@
// Package for the masked vector ALU: operation codes, lane types, command and status structs.
// No dependencies.
`default_nettype none
package mva_pkg;
    localparam int unsigned MODE_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned MAX_LANES = 4;

    localparam logic [MODE_W-1:0] OP_BCAST   = 5'd0;
    localparam logic [MODE_W-1:0] OP_MOVE    = 5'd1;
    localparam logic [MODE_W-1:0] OP_ADD     = 5'd2;
    localparam logic [MODE_W-1:0] OP_SUB     = 5'd3;
    localparam logic [MODE_W-1:0] OP_MUL     = 5'd4;
    localparam logic [MODE_W-1:0] OP_DIV     = 5'd5;
    localparam logic [MODE_W-1:0] OP_SRA     = 5'd6;
    localparam logic [MODE_W-1:0] OP_AND     = 5'd7;
    localparam logic [MODE_W-1:0] OP_ABS     = 5'd8;
    localparam logic [MODE_W-1:0] OP_GT      = 5'd9;
    localparam logic [MODE_W-1:0] OP_LT      = 5'd10;
    localparam logic [MODE_W-1:0] OP_EQ      = 5'd11;
    localparam logic [MODE_W-1:0] OP_PAIRADD = 5'd12;
    localparam logic [MODE_W-1:0] OP_ILEAVE  = 5'd13;
    localparam logic [MODE_W-1:0] OP_MNOT    = 5'd14;
    localparam logic [MODE_W-1:0] OP_MOR     = 5'd15;
    localparam logic [MODE_W-1:0] OP_MAND    = 5'd16;
    localparam logic [MODE_W-1:0] OP_POPCNT  = 5'd17;
    localparam logic [MODE_W-1:0] OP_FIRSTN  = 5'd18;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic load;     // capture the input item
        logic exec;     // apply the operation of a non-divide mode
        logic div_start;
        logic div_step;
        logic div_done; // write quotients
    } cmd_t;

    typedef struct packed {
        logic is_div;
        logic div_last;
    } status_t;
endpackage
`default_nettype wire

@@ hw/rtl/masked_vector_alu.sv @@
// Top level of the masked vector ALU: stream ports, controller and datapath.
// Depends on mva_pkg, mva_ctrl, mva_datapath.
//
// channel  dir  payload
// s_axis   in   tdata: mode, lane_mask, mask_b, scalar, a0..a3, b0..b3
// m_axis   out  tdata: r0..r3, result_mask, bit_count, div_zero
//
// One item at a time: each result is registered before m_axis shows it; divide goes through
// setup, 32 quotient-bit iterations and write-back before its result is written.
// The result holds on m_axis until taken; the next item is accepted after that.
// Reset clears the destination vector and mask register to zero.
`default_nettype none
module masked_vector_alu #(
    parameter int unsigned LANES = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // mode[4:0], lane_mask[8:5], mask_b[12:9], scalar[44:13],
    // a0..a3 [172:45], b0..b3 [300:173], zero [303:301]
    input  wire logic [303:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // r0..r3 [127:0], result_mask[131:128], bit_count[134:132], div_zero[135]
    output logic [135:0]      m_axis_tdata
);
    mva_pkg::cmd_t cmd;
    mva_pkg::status_t status;
    mva_pkg::word_t a_in [mva_pkg::MAX_LANES];
    mva_pkg::word_t b_in [mva_pkg::MAX_LANES];
    mva_pkg::word_t r_out [mva_pkg::MAX_LANES];
    logic [3:0] result_mask;
    logic [2:0] bit_count;
    logic div_zero;

    always_comb
    begin
        for (int i = 0; i < mva_pkg::MAX_LANES; i++)
        begin
            a_in[i] = s_axis_tdata[45 + 32*i +: 32];
            b_in[i] = s_axis_tdata[173 + 32*i +: 32];
        end
    end

    mva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .out_fire  (m_axis_tvalid && m_axis_tready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    mva_datapath #(.LANES(LANES)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (s_axis_tdata[4:0]),
        .lane_mask   (s_axis_tdata[8:5]),
        .mask_b      (s_axis_tdata[12:9]),
        .scalar      (s_axis_tdata[44:13]),
        .a_in        (a_in),
        .b_in        (b_in),
        .r_out       (r_out),
        .result_mask (result_mask),
        .bit_count   (bit_count),
        .div_zero    (div_zero)
    );

    assign m_axis_tdata = {div_zero, bit_count, result_mask,
                           r_out[3], r_out[2], r_out[1], r_out[0]};
endmodule
`default_nettype wire

@@ hw/rtl/mva_ctrl.sv @@
// Controller of the masked vector ALU: sequences load, execute, divide and output.
// Depends on mva_pkg.
`default_nettype none
module mva_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic             out_fire,
    input  wire mva_pkg::status_t status,
    output mva_pkg::cmd_t         cmd,
    output logic                  in_ready,
    output logic                  out_valid
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
                if (in_fire)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (status.is_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.exec = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // quotients are complete only after the last step has landed
                cmd.div_done = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/mva_datapath.sv @@
// Datapath of the masked vector ALU: operand registers, lane logic, restoring dividers, state.
// Depends on mva_pkg.
`default_nettype none
module mva_datapath #(
    parameter int unsigned LANES = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mva_pkg::cmd_t              cmd,
    output mva_pkg::status_t                status,
    input  wire logic [mva_pkg::MODE_W-1:0] mode,
    input  wire logic [3:0]                 lane_mask,
    input  wire logic [3:0]                 mask_b,
    input  wire mva_pkg::word_t             scalar,
    input  wire mva_pkg::word_t             a_in [mva_pkg::MAX_LANES],
    input  wire mva_pkg::word_t             b_in [mva_pkg::MAX_LANES],
    output mva_pkg::word_t                  r_out [mva_pkg::MAX_LANES],
    output logic [3:0]                      result_mask,
    output logic [2:0]                      bit_count,
    output logic                            div_zero
);
    localparam int unsigned W = mva_pkg::DATA_W;
    localparam logic [3:0] LANE_BITS = 4'((1 << LANES) - 1);

    logic [mva_pkg::MODE_W-1:0] mode_reg;
    logic [3:0] en_reg, mb_reg, mask_reg, mask_next;
    mva_pkg::word_t sc_reg;
    mva_pkg::word_t a_reg [mva_pkg::MAX_LANES];
    mva_pkg::word_t b_reg [mva_pkg::MAX_LANES];
    mva_pkg::word_t dest_reg [mva_pkg::MAX_LANES];
    mva_pkg::word_t dest_next [mva_pkg::MAX_LANES];
    logic [2:0] cnt_reg, cnt_next;
    logic dz_reg, dz_next;

    // divider: unsigned restoring, one quotient bit per lane per cycle
    mva_pkg::word_t quo_reg [mva_pkg::MAX_LANES];
    mva_pkg::word_t rem_reg [mva_pkg::MAX_LANES];
    mva_pkg::word_t dvs_reg [mva_pkg::MAX_LANES];
    logic [4:0] step_reg;

    assign status.is_div = (mode_reg == mva_pkg::OP_DIV);
    assign status.div_last = (step_reg == 5'd31);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            en_reg <= lane_mask & LANE_BITS;
            mb_reg <= mask_b & LANE_BITS;
            sc_reg <= scalar;
            a_reg <= a_in;
            b_reg <= b_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mva_pkg::MAX_LANES; i++)
        begin
            if (cmd.div_start)
            begin
                quo_reg[i] <= a_reg[i][W-1] ? (~a_reg[i] + 1'b1) : a_reg[i];
                dvs_reg[i] <= b_reg[i][W-1] ? (~b_reg[i] + 1'b1) : b_reg[i];
                rem_reg[i] <= '0;
            end
            else if (cmd.div_step)
            begin
                logic [W:0] t;
                t = {rem_reg[i], quo_reg[i][W-1]};
                if (t >= {1'b0, dvs_reg[i]})
                begin
                    rem_reg[i] <= W'(t - {1'b0, dvs_reg[i]});
                    quo_reg[i] <= {quo_reg[i][W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= t[W-1:0];
                    quo_reg[i] <= {quo_reg[i][W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.div_start)
            step_reg <= '0;
        else if (cmd.div_step)
            step_reg <= step_reg + 5'd1;
    end

    always_comb
    begin
        mask_next = mask_reg;
        cnt_next = '0;
        dz_next = 1'b0;
        for (int i = 0; i < mva_pkg::MAX_LANES; i++)
            dest_next[i] = dest_reg[i];
        for (int i = 0; i < LANES; i++)
        begin
            logic on;
            logic signed [W-1:0] sa, sb;
            logic c;
            mva_pkg::word_t prod;
            int idx;
            on = en_reg[i];
            sa = a_reg[i];
            sb = b_reg[i];
            prod = a_reg[i] * b_reg[i];
            idx = (i < LANES/2) ? 2*i : 2*(i - LANES/2) + 1;
            c = 1'b0;
            case (mode_reg)
                mva_pkg::OP_BCAST: if (on) dest_next[i] = sc_reg;
                mva_pkg::OP_MOVE:  if (on) dest_next[i] = a_reg[i];
                mva_pkg::OP_ADD:   if (on) dest_next[i] = a_reg[i] + b_reg[i];
                mva_pkg::OP_SUB:   if (on) dest_next[i] = a_reg[i] - b_reg[i];
                mva_pkg::OP_MUL:   if (on) dest_next[i] = prod;
                mva_pkg::OP_SRA:   if (on) dest_next[i] = W'(sa >>> b_reg[i][4:0]);
                mva_pkg::OP_AND:   if (on) dest_next[i] = a_reg[i] & b_reg[i];
                mva_pkg::OP_ABS:
                    if (on) dest_next[i] = a_reg[i][W-1] ? (~a_reg[i] + 1'b1) : a_reg[i];
                mva_pkg::OP_GT, mva_pkg::OP_LT, mva_pkg::OP_EQ:
                begin
                    if (mode_reg == mva_pkg::OP_GT)
                        c = sa > sb;
                    else if (mode_reg == mva_pkg::OP_LT)
                        c = sa < sb;
                    else
                        c = sa == sb;
                    if (on) mask_next[i] = c;
                end
                mva_pkg::OP_PAIRADD:
                    if ((i | 1) < LANES)
                        dest_next[i] = a_reg[i & ~1] + a_reg[i | 1];
                mva_pkg::OP_ILEAVE:
                    if (idx < LANES) dest_next[i] = a_reg[idx[1:0]];
                mva_pkg::OP_DIV:
                begin
                    if (on && b_reg[i] == '0)
                        dz_next = 1'b1;
                    else if (on)
                        dest_next[i] = (a_reg[i][W-1] ^ b_reg[i][W-1]) ?
                                       (~quo_reg[i] + 1'b1) : quo_reg[i];
                end
                default: ;
            endcase
        end
        case (mode_reg)
            mva_pkg::OP_MNOT:   mask_next = ~en_reg & LANE_BITS;
            mva_pkg::OP_MOR:    mask_next = en_reg | mb_reg;
            mva_pkg::OP_MAND:   mask_next = en_reg & mb_reg;
            mva_pkg::OP_POPCNT:
                cnt_next = 3'(en_reg[0]) + 3'(en_reg[1]) + 3'(en_reg[2]) + 3'(en_reg[3]);
            mva_pkg::OP_FIRSTN:
            begin
                mask_next = '0;
                for (int i = 0; i < LANES; i++)
                    if ($signed(sc_reg) > i) mask_next[i] = 1'b1;
            end
            default: ;
        endcase
        mask_next = mask_next & LANE_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            cnt_reg <= '0;
            dz_reg <= 1'b0;
            for (int i = 0; i < mva_pkg::MAX_LANES; i++)
                dest_reg[i] <= '0;
        end
        else if (cmd.exec || cmd.div_done)
        begin
            mask_reg <= mask_next;
            cnt_reg <= cnt_next;
            dz_reg <= dz_next;
            dest_reg <= dest_next;
        end
    end

    assign r_out = dest_reg;
    assign result_mask = mask_reg;
    assign bit_count = cnt_reg;
    assign div_zero = dz_reg;
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Testbench for masked_vector_alu: random and directed vector operations, checked
// against a lane-level predictor held in a small scoreboard class. Depends on mva_pkg.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLANES = 4;

    typedef struct packed {
        logic [31:0] b3, b2, b1, b0, a3, a2, a1, a0;
        logic [31:0] scalar;
        logic [3:0]  mask_b;
        logic [3:0]  lane_mask;
        logic [4:0]  mode;
    } vec_cmd_t;

    typedef struct packed {
        logic        div_zero;
        logic [2:0]  bit_count;
        logic [3:0]  result_mask;
        logic [31:0] r3, r2, r1, r0;
    } vec_res_t;

    class alu_scoreboard;
        logic [31:0] dest[NLANES];
        logic [3:0]  mreg;
        vec_res_t    pending[$];
        int          mismatches;
        int          checked;

        function new();
            foreach (dest[i]) dest[i] = '0;
            mreg = '0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void note_cmd(vec_cmd_t c);
            logic [31:0] a[4], b[4], nv[4];
            logic [3:0]  en, mb, m;
            logic        on, dz, cmp;
            logic [2:0]  cnt;
            int          idx;
            vec_res_t    r;
            a = '{c.a0, c.a1, c.a2, c.a3};
            b = '{c.b0, c.b1, c.b2, c.b3};
            en = c.lane_mask;
            mb = c.mask_b;
            dz = 0;
            cnt = 0;
            for (int i = 0; i < 4; i++) nv[i] = dest[i];
            for (int i = 0; i < NLANES; i++)
            begin
                on = en[i];
                if (c.mode <= mva_pkg::OP_ABS && !on) continue;
                case (c.mode)
                    mva_pkg::OP_BCAST: nv[i] = c.scalar;
                    mva_pkg::OP_MOVE:  nv[i] = a[i];
                    mva_pkg::OP_ADD:   nv[i] = a[i] + b[i];
                    mva_pkg::OP_SUB:   nv[i] = a[i] - b[i];
                    mva_pkg::OP_MUL:   nv[i] = a[i] * b[i];
                    mva_pkg::OP_DIV:
                    begin
                        if (b[i] == 0) dz = 1;
                        else if (a[i] == 32'h8000_0000 && b[i] == '1) nv[i] = a[i];
                        else nv[i] = $signed(a[i]) / $signed(b[i]);
                    end
                    mva_pkg::OP_SRA:   nv[i] = $signed(a[i]) >>> b[i][4:0];
                    mva_pkg::OP_AND:   nv[i] = a[i] & b[i];
                    mva_pkg::OP_ABS:   nv[i] = a[i][31] ? -a[i] : a[i];
                    mva_pkg::OP_GT, mva_pkg::OP_LT, mva_pkg::OP_EQ:
                    begin
                        if (on)
                        begin
                            cmp = (c.mode == mva_pkg::OP_GT) ?
                                      ($signed(a[i]) > $signed(b[i]))
                                : (c.mode == mva_pkg::OP_LT) ?
                                      ($signed(a[i]) < $signed(b[i]))
                                : (a[i] == b[i]);
                            mreg[i] = cmp;
                        end
                    end
                    mva_pkg::OP_PAIRADD:
                        if ((i | 1) < NLANES) nv[i] = a[i & ~1] + a[i | 1];
                    mva_pkg::OP_ILEAVE:
                    begin
                        idx = (i < NLANES / 2) ? 2 * i : 2 * (i - NLANES / 2) + 1;
                        if (idx < NLANES) nv[i] = a[idx];
                    end
                    default: ;
                endcase
            end
            case (c.mode)
                mva_pkg::OP_MNOT: mreg = ~en;
                mva_pkg::OP_MOR:  mreg = en | mb;
                mva_pkg::OP_MAND: mreg = en & mb;
                mva_pkg::OP_POPCNT:
                    cnt = 3'(en[0]) + 3'(en[1]) + 3'(en[2]) + 3'(en[3]);
                mva_pkg::OP_FIRSTN:
                begin
                    m = '0;
                    for (int i = 0; i < NLANES; i++)
                        if ($signed(c.scalar) > i) m[i] = 1;
                    mreg = m;
                end
                default: ;
            endcase
            for (int i = 0; i < NLANES; i++) dest[i] = nv[i];
            r = '{dz, cnt, mreg, nv[3], nv[2], nv[1], nv[0]};
            pending.push_back(r);
        endfunction

        function void check_result(vec_res_t got);
            vec_res_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.r0 !== want.r0 || got.r1 !== want.r1 || got.r2 !== want.r2
                || got.r3 !== want.r3 || got.result_mask !== want.result_mask
                || got.bit_count !== want.bit_count || got.div_zero !== want.div_zero)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: expected %h got %h", checked, want, got);
            end
        endfunction
    endclass

    logic          clk = 0;
    logic          rst_n = 0;
    logic          s_axis_tvalid = 0;
    wire logic     s_axis_tready;
    logic [303:0]  s_axis_tdata = '0;
    wire logic     m_axis_tvalid;
    logic          m_axis_tready = 0;
    wire [135:0]   m_axis_tdata;

    alu_scoreboard sb = new();
    bit  quiet_tail = 0;
    bit  hold_sink = 0;
    int  sent = 0;

    masked_vector_alu #(.LANES(NLANES)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_cmd(vec_cmd_t'(s_axis_tdata[300:0]));
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(vec_res_t'(m_axis_tdata));
    end

    // Sink: random stall bursts, optional long hold-off, none in the tail.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink) m_axis_tready <= 0;
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                m_axis_tready <= 1;
            end
            else m_axis_tready <= 1;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            4: return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_cmd(input vec_cmd_t c);
        s_axis_tdata  <= {3'b000, c};
        s_axis_tvalid <= 1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sent++;
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
    endtask

    function automatic vec_cmd_t rand_cmd();
        vec_cmd_t c;
        c.mode = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(19, 31))
                                              : 5'($urandom_range(0, 18));
        c.lane_mask = 4'($urandom);
        c.mask_b = 4'($urandom);
        c.scalar = (c.mode == mva_pkg::OP_FIRSTN && $urandom_range(0, 1)) ?
                   $urandom_range(0, 8) - 3 : rand_word();
        c.a0 = rand_word(); c.a1 = rand_word(); c.a2 = rand_word(); c.a3 = rand_word();
        c.b0 = rand_word(); c.b1 = rand_word(); c.b2 = rand_word(); c.b3 = rand_word();
        if (c.mode == mva_pkg::OP_DIV && $urandom_range(0, 3) == 0) c.b1 = '0;
        return c;
    endfunction

    initial
    begin
        vec_cmd_t c;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // Directed: every operation and unused mode 19 with extreme operands, then the special cases.
        for (int m = 0; m <= 19; m++)
        begin
            c = rand_cmd();
            c.mode = 5'(m);
            c.lane_mask = (m % 2) ? 4'hf : 4'h5;
            c.a0 = 32'h8000_0000; c.b0 = '1;
            c.a1 = 32'h7fff_ffff; c.b1 = '0;
            c.a2 = 32'hffff_fff0; c.b2 = 32'd35;
            c.scalar = (m == mva_pkg::OP_FIRSTN) ? 32'd2 : 32'h8000_0000;
            send_cmd(c);
        end
        c = rand_cmd(); c.mode = mva_pkg::OP_FIRSTN; c.scalar = 32'h7fff_ffff; send_cmd(c);
        c = rand_cmd(); c.mode = mva_pkg::OP_FIRSTN; c.scalar = '0; send_cmd(c);
        c = rand_cmd(); c.mode = 5'd31; send_cmd(c);
        c = rand_cmd(); c.mode = mva_pkg::OP_POPCNT; c.lane_mask = 4'hf; send_cmd(c);
        while (sent < 1750)
        begin
            if (sent == 600) fork begin hold_sink = 1; repeat (300) @(posedge clk); hold_sink = 0; end join_none
            if (sent >= 1550) quiet_tail = 1;
            send_cmd(rand_cmd());
        end
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d items over all 19 operations plus unused modes, %0d results checked.",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("masked_vector_alu verification clean");
        else
            $display("masked_vector_alu verification failed");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("masked_vector_alu verification failed");
        $finish;
    end
endmodule
`default_nettype wire
